[rtl/mhpq_pkg.sv]
// Shared types and codes for the min-heap priority queue.
// No dependencies.
package mhpq_pkg;

    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 11;
    localparam int KEY_IO_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_PEEK = 2'd1,
        OP_POP  = 2'd2,
        OP_POPM = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_UPRD  = 10'b00_0000_0010,
        S_UPCMP = 10'b00_0000_0100,
        S_RMRD  = 10'b00_0000_1000,
        S_LAST  = 10'b00_0001_0000,
        S_DNRD  = 10'b00_0010_0000,
        S_DNCMP = 10'b00_0100_0000,
        S_ROOT  = 10'b00_1000_0000,
        S_CHK   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

endpackage

[rtl/mhpq_store.sv]
// Heap key store: one write port, two synchronous read ports.
// Depends on nothing; sized by its parameters.
module mhpq_store #(
    parameter int DEPTH     = 1024,
    parameter int KEY_WIDTH = 32,
    parameter int AW        = 10
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [KEY_WIDTH-1:0] wdata,
    input  logic [AW-1:0]        raddr_a,
    input  logic [AW-1:0]        raddr_b,
    output logic [KEY_WIDTH-1:0] rdata_a,
    output logic [KEY_WIDTH-1:0] rdata_b
);

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/min_heap_priority_queue_unit.sv]
// Min-heap priority queue top level: sequencer over mhpq_store, uses mhpq_pkg.
// A push sifts the new key up from the last slot, a pop moves the last key to
// the root and sifts it down, and pop-multiple repeats the pop walk per copy
// with a root re-check after each. One request at a time, next accepted after
// the result. Reset: no keys, limit 1024, store kept.
module min_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [KEY_IO_W-1:0]  key_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_IO_W-1:0]  key_out,
    output logic [CFG_W-1:0]     copies_removed,
    output logic [STAT_W-1:0]    status,
    output logic [CFG_W-1:0]     occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CFG_W-1:0]     cap_reg;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] min_reg, min_next;
    logic [CW-1:0]        copies_reg, copies_next;
    logic                 popm_reg, popm_next;
    logic [STAT_W-1:0]    stat_reg, stat_next;
    logic                 ov_reg;
    logic                 ov_next;
    logic [KEY_IO_W-1:0]  ko_reg, ko_next;
    logic [CFG_W-1:0]     cr_reg, cr_next;
    logic [STAT_W-1:0]    st_reg, st_next;
    logic [CFG_W-1:0]     oc_reg, oc_next;

    logic                 we;
    logic [AW-1:0]        waddr, ra, rb;
    logic [KEY_WIDTH-1:0] wdata, rda, rdb;

    mhpq_store #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .AW(AW)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
    );

    // effective limit = min(capacity_limit, DEPTH)
    logic [CW+CFG_W-1:0] limit_w, cap_w, depth_w;
    assign cap_w   = (CW+CFG_W)'(cap_reg);
    assign depth_w = (CW+CFG_W)'(DEPTH);
    assign limit_w = (cap_w < depth_w) ? cap_w : depth_w;

    // child indices of the current sift position
    logic [XW-1:0] lidx, ridx, cnt_x;
    assign lidx  = {1'b0, pos_reg, 1'b1};
    assign ridx  = lidx + XW'(1);
    assign cnt_x = XW'(count_reg);
    logic [AW-1:0] parent;
    assign parent = (pos_reg - AW'(1)) >> 1;

    logic out_free;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;

    // child choice: right on tie
    logic                 has_r;
    logic [KEY_WIDTH-1:0] ckey;
    logic [AW-1:0]        cidx;
    assign has_r = ridx < cnt_x;
    always_comb
    begin
        if (has_r && !(rda < rdb))
        begin
            ckey = rdb;
            cidx = ridx[AW-1:0];
        end
        else
        begin
            ckey = rda;
            cidx = lidx[AW-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        min_next    = min_reg;
        copies_next = copies_reg;
        popm_next   = popm_reg;
        stat_next   = stat_reg;
        we    = 1'b0;
        waddr = pos_reg;
        wdata = key_reg;
        ra    = '0;
        rb    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // root read runs every idle cycle
                ra = '0;
                if (in_valid && out_free)
                begin
                    copies_next = '0;
                    stat_next   = ST_OK;
                    min_next    = '0;
                    popm_next   = (operation == OP_POPM);
                    if (operation == OP_PUSH)
                    begin
                        if ((CW+CFG_W)'(count_reg) >= limit_w)
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            key_next   = KEY_WIDTH'(key_in);
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = S_UPRD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        stat_next  = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else if (operation == OP_PEEK)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        state_next = S_RMRD;
                    end
                end
            end
            S_UPRD:
            begin
                ra = parent;
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = key_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (rda > key_reg)
                begin
                    // move parent down, continue one level up
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = rda;
                    pos_next   = parent;
                    state_next = S_UPRD;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = key_reg;
                    state_next = S_DONE;
                end
            end
            S_ROOT:
            begin
                // root read after the last sift write has landed
                ra         = '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // rda = root
                if (!popm_reg)
                begin
                    min_next   = rda;
                    state_next = S_DONE;
                end
                else if (count_reg != '0 && rda == min_reg)
                begin
                    state_next = S_RMRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RMRD:
            begin
                // rda = root on the first removal; fetch last entry
                ra = AW'(count_reg - CW'(1));
                if (copies_reg == '0)
                begin
                    min_next = rda;
                end
                copies_next = copies_reg + CW'(1);
                count_next  = count_reg - CW'(1);
                pos_next    = '0;
                state_next  = S_LAST;
            end
            S_LAST:
            begin
                // rda = last key, becomes the sifting key at the root
                key_next = rda;
                ra       = lidx[AW-1:0];
                rb       = has_r ? ridx[AW-1:0] : lidx[AW-1:0];
                if (lidx >= cnt_x)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = rda;
                    state_next = popm_reg ? S_ROOT : S_DONE;
                end
                else
                begin
                    state_next = S_DNCMP;
                end
            end
            S_DNRD:
            begin
                // fetch children of the new position
                ra = lidx[AW-1:0];
                rb = has_r ? ridx[AW-1:0] : lidx[AW-1:0];
                if (lidx >= cnt_x)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = key_reg;
                    state_next = popm_reg ? S_ROOT : S_DONE;
                end
                else
                begin
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP:
            begin
                if (key_reg > ckey)
                begin
                    // move smaller child up, continue one level down
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = ckey;
                    pos_next   = cidx;
                    state_next = S_DNRD;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = key_reg;
                    state_next = popm_reg ? S_ROOT : S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result formation
    always_comb
    begin
        ov_next = ov_reg && out_stall;
        ko_next = ko_reg;
        cr_next = cr_reg;
        st_next = st_reg;
        oc_next = oc_reg;
        if (state_reg == S_DONE)
        begin
            ov_next = 1'b1;
            ko_next = KEY_IO_W'(min_reg);
            cr_next = CFG_W'(copies_reg);
            st_next = stat_reg;
            oc_next = CFG_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CFG_W'(1024);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        min_reg    <= min_next;
        copies_reg <= copies_next;
        popm_reg   <= popm_next;
        stat_reg   <= stat_next;
        ko_reg     <= ko_next;
        cr_reg     <= cr_next;
        st_reg     <= st_next;
        oc_reg     <= oc_next;
    end

    assign out_valid      = ov_reg;
    assign key_out        = ko_reg;
    assign copies_removed = cr_reg;
    assign status         = st_reg;
    assign occupancy      = oc_reg;

endmodule
